// ===== src/vad_pkg.sv =====
package vad_pkg;

    // Stream widths.
    localparam int COORD_W  = 32;
    localparam int S_DATA_W = 4 * COORD_W;
    localparam int ANGLE_W  = 24;

    // Internal widths.
    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int XY_W   = 34;
    localparam int Z_W    = 64;
    localparam int R_W    = 34;
    localparam int NUM_W  = 58;
    localparam int RECIP_SHIFT = 34;

    // Number of conditional shift cells that normalize the operand pair.
    localparam int NORM_STEPS = 6;

    // Angle constants. Radians are Q60, degrees are Q8.16.
    localparam logic [Z_W-1:0]     PI_Q60    = 64'h3243F6A8885A308D;
    localparam logic [Z_W-1:0]     HALF_PI   = PI_Q60 >> 1;
    localparam logic [ANGLE_W-1:0] DEG180    = 24'd11796480;
    localparam logic [ANGLE_W-1:0] DEG90     = 24'd5898240;
    localparam logic [R_W-1:0]     PI_SCALED = R_W'(PI_Q60 >> 28);
    localparam logic [ANGLE_W-1:0] DEG_RECIP =
        ANGLE_W'(({40'd0, DEG180} << RECIP_SHIFT) / {30'd0, PI_SCALED});

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic signed [XY_W-1:0]    xy_t;
    typedef logic signed [Z_W-1:0]     z_t;
    typedef logic [ANGLE_W-1:0]        angle_t;

    // How the final angle is formed.
    typedef enum logic [2:0] {
        KIND_CORDIC,
        KIND_ZERO_VEC,
        KIND_SAME_DIR,
        KIND_OPPOSITE,
        KIND_RIGHT
    } angle_kind_t;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        logic        valid;
        angle_kind_t kind;
        logic        obtuse;
    } ctrl_t;

    // Quotient of n by the k-th odd number (1, 3, 5, ...).
    function automatic logic [63:0] div_odd(input logic [63:0] n, input int unsigned k);
        logic [63:0] q;
        case (k)
            0:  q = n;
            1:  q = n / 64'd3;
            2:  q = n / 64'd5;
            3:  q = n / 64'd7;
            4:  q = n / 64'd9;
            5:  q = n / 64'd11;
            6:  q = n / 64'd13;
            7:  q = n / 64'd15;
            8:  q = n / 64'd17;
            9:  q = n / 64'd19;
            10: q = n / 64'd21;
            11: q = n / 64'd23;
            12: q = n / 64'd25;
            13: q = n / 64'd27;
            14: q = n / 64'd29;
            15: q = n / 64'd31;
            16: q = n / 64'd33;
            17: q = n / 64'd35;
            18: q = n / 64'd37;
            19: q = n / 64'd39;
            20: q = n / 64'd41;
            21: q = n / 64'd43;
            22: q = n / 64'd45;
            23: q = n / 64'd47;
            24: q = n / 64'd49;
            25: q = n / 64'd51;
            26: q = n / 64'd53;
            27: q = n / 64'd55;
            28: q = n / 64'd57;
            29: q = n / 64'd59;
            default: q = '0;
        endcase
        return q;
    endfunction

    // atan(2^-i) in Q60 radians, from the truncated arctangent series.
    function automatic logic [63:0] atan_rom(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned k;
        sum  = '0;
        term = '0;
        if (i == 0)
        begin
            sum = PI_Q60 >> 2;
        end
        else
        begin
            for (k = 0; k < 30; k++)
            begin
                if (i * (2 * k + 1) <= 60)
                begin
                    term = div_odd(64'd1 << (60 - i * (2 * k + 1)), k);
                    if (k[0])
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

endpackage

// ===== src/vector_angle_2d_degrees.sv =====
// Channel   Direction  Ports           Contents
// --------  ---------  --------------  ------------------------------------------------
// s_axis    in         tvalid/tready   tdata: first_x, first_y, second_x, second_y
// m_axis    out        tvalid/tready   tdata: angle_deg; tuser: zero_vector
//
// One item is accepted per cycle while the skid register is empty. The path of each
// result is the row of CORDIC cells, one cell per iteration up to 32, plus three
// product stages, six normalization cells, four scaling stages and the output register.
// Reset clears only valid bits and control words; the block holds no state between items.
// A stall on m_axis parks one result in a skid register, and s_axis_tready falls
// only while that register is full, freezing the whole pipeline.
module vector_angle_2d_degrees #(
    parameter int ANGLE_ITERATIONS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_x [31:0], first_y [63:32], second_x [95:64], second_y [127:96]
    input  logic [vad_pkg::S_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // angle_deg [23:0]
    output logic [vad_pkg::ANGLE_W-1:0]     m_axis_tdata,
    // zero_vector [0]
    output logic                            m_axis_tuser
);
    import vad_pkg::*;

    // The iteration count never goes past 32 steps.
    localparam int STAGES = (ANGLE_ITERATIONS < 32) ? ANGLE_ITERATIONS : 32;

    // The whole pipeline moves as one while the skid register is free.
    logic  en;

    ctrl_t norm_ctrl [0:NORM_STEPS];
    mag_t  norm_ux   [0:NORM_STEPS];
    mag_t  norm_uy   [0:NORM_STEPS];

    ctrl_t cor_ctrl  [0:STAGES];
    xy_t   cor_x     [0:STAGES];
    xy_t   cor_y     [0:STAGES];
    z_t    cor_z     [0:STAGES];

    logic   res_valid;
    angle_t res_angle;
    logic   res_zero;

    logic   out_valid_reg, out_valid_next;
    angle_t out_angle_reg, out_angle_next;
    logic   out_zero_reg, out_zero_next;
    logic   skid_valid_reg, skid_valid_next;
    angle_t skid_angle_reg, skid_angle_next;
    logic   skid_zero_reg, skid_zero_next;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // Products, dot and cross, magnitudes and the special cases.
    vad_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .out_ctrl (norm_ctrl[0]),
        .out_ux   (norm_ux[0]),
        .out_uy   (norm_uy[0])
    );

    // Binary normalization: shifts of 32, 16, 8, 4, 2 and 1 bring the top set
    // bit of the larger operand to the top of the word.
    for (genvar g = 0; g < NORM_STEPS; g++)
    begin : g_norm
        vad_norm_cell #(
            .SHIFT (32 >> g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_ctrl  (norm_ctrl[g]),
            .in_ux    (norm_ux[g]),
            .in_uy    (norm_uy[g]),
            .out_ctrl (norm_ctrl[g+1]),
            .out_ux   (norm_ux[g+1]),
            .out_uy   (norm_uy[g+1])
        );
    end

    // The CORDIC takes the top 31 bits, so the larger operand lands at bit 30.
    // An obtuse pair starts the angle at pi/2.
    assign cor_ctrl[0] = norm_ctrl[NORM_STEPS];
    assign cor_x[0]    = XY_W'(norm_ux[NORM_STEPS][MAG_W-1:MAG_W-31]);
    assign cor_y[0]    = XY_W'(norm_uy[NORM_STEPS][MAG_W-1:MAG_W-31]);
    assign cor_z[0]    = norm_ctrl[NORM_STEPS].obtuse ? HALF_PI : '0;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cordic
        vad_cordic_cell #(
            .INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_ctrl  (cor_ctrl[g]),
            .in_x     (cor_x[g]),
            .in_y     (cor_y[g]),
            .in_z     (cor_z[g]),
            .out_ctrl (cor_ctrl[g+1]),
            .out_x    (cor_x[g+1]),
            .out_y    (cor_y[g+1]),
            .out_z    (cor_z[g+1])
        );
    end

    // Radians to rounded degrees, then the special-case angles.
    vad_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctrl   (cor_ctrl[STAGES]),
        .in_z      (cor_z[STAGES]),
        .out_valid (res_valid),
        .out_angle (res_angle),
        .out_zero  (res_zero)
    );

    // Output register with a skid register behind it. The x and y of the last
    // cell are not needed; only the accumulated angle goes on.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_angle_next  = out_angle_reg;
        out_zero_next   = out_zero_reg;
        skid_valid_next = skid_valid_reg;
        skid_angle_next = skid_angle_reg;
        skid_zero_next  = skid_zero_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_valid_next  = 1'b1;
                out_angle_next  = skid_angle_reg;
                out_zero_next   = skid_zero_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_next = res_valid;
            out_angle_next = res_angle;
            out_zero_next  = res_zero;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_angle_next = res_angle;
            skid_zero_next  = res_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg  <= out_angle_next;
        out_zero_reg   <= out_zero_next;
        skid_angle_reg <= skid_angle_next;
        skid_zero_reg  <= skid_zero_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_angle_reg;
    assign m_axis_tuser  = out_zero_reg;

`ifndef SYNTHESIS
    // The skid register only fills behind a result that is still waiting.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A parked result stays parked, unchanged, until the output drains.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_axis_tready |=> skid_valid_reg && $stable(skid_angle_reg))
        else $error("skid register lost or changed its item during a stall");

    // A zero-length vector always reports an angle of zero.
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero vector flagged with a nonzero angle");

    // The angle never leaves 0 to 180 degrees.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= DEG180)
        else $error("angle above 180 degrees");
`endif

endmodule

// ===== src/vad_prep.sv =====
module vad_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [vad_pkg::S_DATA_W-1:0]         in_data,
    output vad_pkg::ctrl_t                       out_ctrl,
    output vad_pkg::mag_t                        out_ux,
    output vad_pkg::mag_t                        out_uy
);
    import vad_pkg::*;

    coord_t ax, ay, bx, by;
    logic   zero_in;

    // Stage 1: the four products.
    prod_t  p_ac_reg, p_bd_reg, p_ad_reg, p_bc_reg;
    prod_t  p_ac_next, p_bd_next, p_ad_next, p_bc_next;
    logic   v1_reg, z1_reg;

    // Stage 2: dot and cross products.
    sum_t   dot_reg, cross_reg, dot_next, cross_next;
    logic   v2_reg, z2_reg;

    // Stage 3: magnitudes, operand order and the special cases.
    mag_t   ux_reg, uy_reg, ux_next, uy_next;
    ctrl_t  ctrl_reg, ctrl_next;
    logic   dot_neg;
    mag_t   dot_mag, cross_mag;

    assign ax = in_data[COORD_W-1:0];
    assign ay = in_data[2*COORD_W-1:COORD_W];
    assign bx = in_data[3*COORD_W-1:2*COORD_W];
    assign by = in_data[4*COORD_W-1:3*COORD_W];

    assign zero_in = ((ax == '0) && (ay == '0)) || ((bx == '0) && (by == '0));

    always_comb
    begin
        p_ac_next  = PROD_W'(ax) * PROD_W'(bx);
        p_bd_next  = PROD_W'(ay) * PROD_W'(by);
        p_ad_next  = PROD_W'(ax) * PROD_W'(by);
        p_bc_next  = PROD_W'(ay) * PROD_W'(bx);
        dot_next   = SUM_W'(p_ac_reg) + SUM_W'(p_bd_reg);
        cross_next = SUM_W'(p_ad_reg) - SUM_W'(p_bc_reg);
    end

    always_comb
    begin
        dot_neg   = dot_reg[SUM_W-1];
        dot_mag   = dot_neg ? MAG_W'(-dot_reg) : MAG_W'(dot_reg);
        cross_mag = cross_reg[SUM_W-1] ? MAG_W'(-cross_reg) : MAG_W'(cross_reg);

        ctrl_next.valid  = v2_reg;
        ctrl_next.obtuse = dot_neg;
        if (z2_reg)
            ctrl_next.kind = KIND_ZERO_VEC;
        else if (cross_reg == '0)
            ctrl_next.kind = dot_neg ? KIND_OPPOSITE : KIND_SAME_DIR;
        else if (dot_reg == '0)
            ctrl_next.kind = KIND_RIGHT;
        else
            ctrl_next.kind = KIND_CORDIC;

        // An obtuse pair starts from a right angle with the roles swapped.
        if (dot_neg)
        begin
            ux_next = cross_mag;
            uy_next = dot_mag;
        end
        else
        begin
            ux_next = dot_mag;
            uy_next = cross_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ac_reg  <= p_ac_next;
            p_bd_reg  <= p_bd_next;
            p_ad_reg  <= p_ad_next;
            p_bc_reg  <= p_bc_next;
            z1_reg    <= zero_in;
            dot_reg   <= dot_next;
            cross_reg <= cross_next;
            z2_reg    <= z1_reg;
            ux_reg    <= ux_next;
            uy_reg    <= uy_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_ux   = ux_reg;
    assign out_uy   = uy_reg;

endmodule

// ===== src/vad_norm_cell.sv =====
module vad_norm_cell #(
    parameter int SHIFT = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  vad_pkg::ctrl_t  in_ctrl,
    input  vad_pkg::mag_t   in_ux,
    input  vad_pkg::mag_t   in_uy,
    output vad_pkg::ctrl_t  out_ctrl,
    output vad_pkg::mag_t   out_ux,
    output vad_pkg::mag_t   out_uy
);
    import vad_pkg::*;

    mag_t  lead;
    mag_t  ux_reg, uy_reg, ux_next, uy_next;
    ctrl_t ctrl_reg;

    // Both operands move up together while the top SHIFT bits of the larger are clear.
    always_comb
    begin
        lead = in_ux | in_uy;
        if (lead[MAG_W-1 -: SHIFT] == '0)
        begin
            ux_next = in_ux << SHIFT;
            uy_next = in_uy << SHIFT;
        end
        else
        begin
            ux_next = in_ux;
            uy_next = in_uy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= in_ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_ux   = ux_reg;
    assign out_uy   = uy_reg;

endmodule

// ===== src/vad_cordic_cell.sv =====
module vad_cordic_cell #(
    parameter int INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  vad_pkg::ctrl_t  in_ctrl,
    input  vad_pkg::xy_t    in_x,
    input  vad_pkg::xy_t    in_y,
    input  vad_pkg::z_t     in_z,
    output vad_pkg::ctrl_t  out_ctrl,
    output vad_pkg::xy_t    out_x,
    output vad_pkg::xy_t    out_y,
    output vad_pkg::z_t     out_z
);
    import vad_pkg::*;

    localparam logic [Z_W-1:0] ATAN = atan_rom(unsigned'(INDEX));

    xy_t   dx, dy;
    xy_t   x_reg, y_reg, x_next, y_next;
    z_t    z_reg, z_next;
    ctrl_t ctrl_reg;

    // One vectoring step: rotate toward the x axis and book the angle.
    always_comb
    begin
        dx = in_y >>> INDEX;
        dy = in_x >>> INDEX;
        if (in_y > 0)
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + $signed(ATAN);
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - $signed(ATAN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= in_ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_z    = z_reg;

endmodule

// ===== src/vad_scale.sv =====
module vad_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  vad_pkg::ctrl_t    in_ctrl,
    input  vad_pkg::z_t       in_z,
    output logic              out_valid,
    output vad_pkg::angle_t   out_angle,
    output logic              out_zero
);
    import vad_pkg::*;

    localparam logic [NUM_W-1:0] P_EXT   = NUM_W'(PI_SCALED);
    localparam logic [NUM_W-1:0] P2_EXT  = P_EXT << 1;
    localparam logic [NUM_W-1:0] HALF_P  = P_EXT >> 1;

    ctrl_t              c1_reg, c2_reg, c3_reg;
    logic               v4_reg;
    logic [R_W-1:0]     r_reg, r_next;
    logic [NUM_W-1:0]   num2_reg, num3_reg, num_next, prod, qp_reg, qp_next;
    angle_t             q2_reg, q3_reg, q_next;
    logic [NUM_W-1:0]   rem;
    logic [1:0]         inc;
    logic [ANGLE_W:0]   d_sum;
    angle_t             d_val;
    angle_t             angle_reg, angle_next;
    logic               zero_reg, zero_next;
    z_t                 z_clamp;

    // Stage 1: clamp the angle to [0, pi] and drop to 34 bits.
    always_comb
    begin
        if (in_z < 0)
            z_clamp = '0;
        else if (in_z > $signed(PI_Q60))
            z_clamp = PI_Q60;
        else
            z_clamp = in_z;
        r_next = z_clamp[R_W+27:28];
    end

    // Stage 2: rounded numerator and a reciprocal estimate of the quotient,
    // which is at most two below the true one.
    always_comb
    begin
        num_next = NUM_W'(r_reg) * NUM_W'(DEG180) + HALF_P;
        prod     = NUM_W'(r_reg) * NUM_W'(DEG_RECIP);
        q_next   = prod[NUM_W-1:RECIP_SHIFT];
    end

    // Stage 3: multiply the estimate back.
    assign qp_next = NUM_W'(q2_reg) * P_EXT;

    // Stage 4: correct the estimate and pick the special-case angles.
    always_comb
    begin
        rem = num3_reg - qp_reg;
        if (rem >= P2_EXT)
            inc = 2'd2;
        else if (rem >= P_EXT)
            inc = 2'd1;
        else
            inc = 2'd0;
        d_sum = (ANGLE_W+1)'(q3_reg) + (ANGLE_W+1)'(inc);
        d_val = (d_sum > (ANGLE_W+1)'(DEG180)) ? DEG180 : d_sum[ANGLE_W-1:0];

        zero_next = 1'b0;
        unique case (c3_reg.kind)
            KIND_ZERO_VEC:
            begin
                angle_next = '0;
                zero_next  = 1'b1;
            end
            KIND_SAME_DIR: angle_next = '0;
            KIND_OPPOSITE: angle_next = DEG180;
            KIND_RIGHT:    angle_next = DEG90;
            KIND_CORDIC:   angle_next = d_val;
            default:       angle_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_reg <= in_ctrl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            v4_reg <= c3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            num2_reg  <= num_next;
            q2_reg    <= q_next;
            num3_reg  <= num2_reg;
            q3_reg    <= q2_reg;
            qp_reg    <= qp_next;
            angle_reg <= angle_next;
            zero_reg  <= zero_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_angle = angle_reg;
    assign out_zero  = zero_reg;

endmodule
